FILE: sv/iounms_pkg.sv
package iounms_pkg;

    localparam int MAX_BOXES_DEF = 64;
    localparam int IDX_W = 6;
    localparam int CNT_W = 7;
    localparam logic [15:0] THR_RESET = 16'd29491;

    typedef struct packed {
        logic signed [15:0] left;
        logic signed [15:0] top;
        logic [14:0]        width;
        logic [14:0]        height;
        logic [15:0]        score;
    } t_box;

    typedef struct packed {
        logic             valid;
        logic [CNT_W-1:0] count;
        logic             overflow;
    } t_job;

    typedef struct packed {
        logic take;
        logic done;
    } t_back_status;

    typedef struct packed {
        logic [IDX_W-1:0] index;
        logic             last;
        logic             overflow;
    } t_result;

endpackage

FILE: sv/iounms_ram.sv
module iounms_ram
    #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
    )(
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/iounms_front.sv
module iounms_front
    import iounms_pkg::*;
    #(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
    )(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         push,
    output logic         full,
    input  logic         i_last_box,
    output logic         o_we,
    output logic [AW-1:0] o_waddr,
    output t_job         o_job,
    input  t_back_status i_status
);

    logic [CNT_W-1:0] r_count;
    logic             r_ovf;
    logic             r_busy;
    t_job             r_job;
    logic             accept;
    logic             stored;

    assign accept  = push && !r_busy;
    assign stored  = r_count < CNT_W'(MAX_BOXES);
    assign o_we    = accept && stored;
    assign o_waddr = r_count[AW-1:0];
    assign full    = r_busy;
    assign o_job   = r_job;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_ovf   <= 1'b0;
            r_busy  <= 1'b0;
            r_job   <= '0;
        end else begin
            if (i_status.take) begin
                r_job.valid <= 1'b0;
            end
            if (i_status.done) begin
                r_busy <= 1'b0;
            end
            if (accept) begin
                if (i_last_box) begin
                    r_job.valid    <= 1'b1;
                    r_job.count    <= stored ? r_count + 1'b1 : r_count;
                    r_job.overflow <= r_ovf || !stored;
                    r_busy         <= 1'b1;
                    r_count        <= '0;
                    r_ovf          <= 1'b0;
                end else if (stored) begin
                    r_count <= r_count + 1'b1;
                end else begin
                    r_ovf <= 1'b1;
                end
            end
        end
    end

endmodule

FILE: sv/iounms_back.sv
module iounms_back
    import iounms_pkg::*;
    #(
    parameter int MAX_BOXES = MAX_BOXES_DEF,
    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1
    )(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  t_job          i_job,
    output t_back_status  o_status,
    output logic [AW-1:0] o_raddr,
    input  t_box          i_rbox,
    input  logic          i_cfg_valid,
    output logic          o_cfg_ready,
    input  logic [15:0]   i_cfg_data,
    output logic          empty,
    input  logic          pop,
    output t_result       o_result
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_SCAN = 3'd1;
    localparam logic [2:0] S_SEL  = 3'd2;
    localparam logic [2:0] S_AREA = 3'd3;
    localparam logic [2:0] S_SUPP = 3'd4;

    logic [2:0]           r_state;
    logic [CNT_W-1:0]     r_n;
    logic                 r_ovf;
    logic [CNT_W-1:0]     r_addr;
    logic [MAX_BOXES-1:0] r_done;
    logic [15:0]          r_thr;
    logic                 r_found;
    t_box                 r_best;
    logic [IDX_W-1:0]     r_best_idx;
    t_box                 r_a;
    logic [IDX_W-1:0]     r_pend_idx;
    logic                 r_pend_v;
    logic [29:0]          r_area_a;
    logic signed [17:0]   r_ra;
    logic signed [17:0]   r_ba;

    logic                 r_v0;
    logic                 r_last0;
    logic [CNT_W-1:0]     r_idx0;
    logic                 r1_v, r2_v, r3_v, r4_v;
    logic                 r1_last, r2_last, r3_last, r4_last;
    logic [CNT_W-1:0]     r1_idx, r2_idx, r3_idx, r4_idx;
    logic [16:0]          r1_iw, r1_ih;
    logic [14:0]          r1_w, r1_h;
    logic [33:0]          r2_inter;
    logic [29:0]          r2_areab;
    logic [33:0]          r3_inter, r3_uni;
    logic [49:0]          r4_lhs, r4_rhs;
    logic                 r4_zero;

    logic [1:0]           r_qv, n_qv;
    t_result              r_qd [2];
    t_result              n_qd [2];

    logic                 issuing;
    logic                 cand;
    logic                 space;
    logic                 push_res;
    t_result              push_data;
    logic                 hit;
    logic                 do_pop;
    logic signed [17:0]   lb, tb, rb, bb, x1, x2, y1, y2, dx, dy;
    logic [16:0]          iw, ih;

    assign issuing     = (r_state == S_SCAN || r_state == S_SUPP) && (r_addr < r_n);
    assign o_raddr     = r_addr[AW-1:0];
    assign o_cfg_ready = 1'b1;
    assign space       = !r_qv[1];
    assign do_pop      = pop && r_qv[0];
    assign empty       = !r_qv[0];
    assign o_result    = r_qd[0];
    assign o_status.take = (r_state == S_IDLE) && i_job.valid;
    assign o_status.done = (r_state == S_SEL) && !r_found && space;

    assign cand = (r_state == S_SCAN) && r_v0 && !r_done[r_idx0[AW-1:0]]
                  && (!r_found || i_rbox.score > r_best.score);

    always_comb begin
        lb = 18'(i_rbox.left);
        tb = 18'(i_rbox.top);
        rb = lb + $signed({3'b000, i_rbox.width});
        bb = tb + $signed({3'b000, i_rbox.height});
        x1 = (18'(r_a.left) > lb) ? 18'(r_a.left) : lb;
        y1 = (18'(r_a.top) > tb) ? 18'(r_a.top) : tb;
        x2 = (r_ra < rb) ? r_ra : rb;
        y2 = (r_ba < bb) ? r_ba : bb;
        dx = x2 - x1;
        dy = y2 - y1;
        iw = (x2 > x1) ? dx[16:0] : '0;
        ih = (y2 > y1) ? dy[16:0] : '0;
    end

    assign hit = r4_v && !r4_zero && (r4_lhs > r4_rhs);

    always_comb begin
        push_res  = 1'b0;
        push_data.index    = r_pend_idx;
        push_data.last     = 1'b0;
        push_data.overflow = r_ovf;
        if (r_state == S_SEL && space) begin
            if (r_found) begin
                push_res = r_pend_v;
            end else begin
                push_res       = 1'b1;
                push_data.last = 1'b1;
            end
        end
        n_qv = r_qv;
        n_qd = r_qd;
        if (do_pop) begin
            n_qd[0] = r_qd[1];
            n_qv    = {1'b0, r_qv[1]};
        end
        if (push_res) begin
            if (!n_qv[0]) begin
                n_qd[0]  = push_data;
                n_qv[0]  = 1'b1;
            end else begin
                n_qd[1]  = push_data;
                n_qv[1]  = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_qd     <= n_qd;
        r_last0  <= (r_addr == r_n - 1'b1);
        r_idx0   <= r_addr;
        r1_last  <= r_last0;
        r1_idx   <= r_idx0;
        r1_iw    <= iw;
        r1_ih    <= ih;
        r1_w     <= i_rbox.width;
        r1_h     <= i_rbox.height;
        r2_last  <= r1_last;
        r2_idx   <= r1_idx;
        r2_inter <= {17'b0, r1_iw} * {17'b0, r1_ih};
        r2_areab <= {15'b0, r1_w} * {15'b0, r1_h};
        r3_last  <= r2_last;
        r3_idx   <= r2_idx;
        r3_inter <= r2_inter;
        r3_uni   <= {4'b0, r_area_a} + {4'b0, r2_areab} - r2_inter;
        r4_last  <= r3_last;
        r4_idx   <= r3_idx;
        r4_lhs   <= {r3_inter[33:0], 16'b0};
        r4_rhs   <= {34'b0, r_thr} * {16'b0, r3_uni};
        r4_zero  <= (r3_uni == '0);
        if (cand) begin
            r_best     <= i_rbox;
            r_best_idx <= r_idx0[IDX_W-1:0];
        end
        if (r_state == S_AREA) begin
            r_area_a <= {15'b0, r_a.width} * {15'b0, r_a.height};
            r_ra     <= 18'(r_a.left) + $signed({3'b000, r_a.width});
            r_ba     <= 18'(r_a.top) + $signed({3'b000, r_a.height});
        end
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_qv     <= '0;
            r_done   <= '0;
            r_found  <= 1'b0;
            r_pend_v <= 1'b0;
            r_addr   <= '0;
            r_n      <= '0;
            r_ovf    <= 1'b0;
            r_thr    <= THR_RESET;
            r_v0     <= 1'b0;
            r1_v     <= 1'b0;
            r2_v     <= 1'b0;
            r3_v     <= 1'b0;
            r4_v     <= 1'b0;
        end else begin
            r_qv <= n_qv;
            r_v0 <= issuing;
            r1_v <= r_v0 && (r_state == S_SUPP);
            r2_v <= r1_v;
            r3_v <= r2_v;
            r4_v <= r3_v;
            if (i_cfg_valid) begin
                r_thr <= i_cfg_data;
            end
            if (issuing) begin
                r_addr <= r_addr + 1'b1;
            end
            if (cand) begin
                r_found <= 1'b1;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_job.valid) begin
                        r_n     <= i_job.count;
                        r_ovf   <= i_job.overflow;
                        r_done  <= '0;
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    if (r_v0 && r_last0) begin
                        r_state <= S_SEL;
                    end
                end
                S_SEL: begin
                    if (r_found) begin
                        if (!r_pend_v || space) begin
                            r_pend_v   <= 1'b1;
                            r_pend_idx <= r_best_idx;
                            r_done[r_best_idx[AW-1:0]] <= 1'b1;
                            r_a        <= r_best;
                            r_state    <= S_AREA;
                        end
                    end else if (space) begin
                        r_pend_v <= 1'b0;
                        r_state  <= S_IDLE;
                    end
                end
                S_AREA: begin
                    r_addr  <= '0;
                    r_state <= S_SUPP;
                end
                S_SUPP: begin
                    if (hit) begin
                        r_done[r4_idx[AW-1:0]] <= 1'b1;
                    end
                    if (r4_v && r4_last) begin
                        r_addr  <= '0;
                        r_found <= 1'b0;
                        r_state <= S_SCAN;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sv/iou_non_maximum_suppression_core.sv
// Boxes load at one item per cycle while full is low; the item that closes a set makes full
// rise until the set is done. The run time of a set is set by the single read port of the
// box memory, scanned twice per kept box.
// Reset is synchronous, active low: it empties the result queue, the set being loaded
// and any set in progress, and restores the threshold to its default; box memory keeps its data.
module iou_non_maximum_suppression_core
    import iounms_pkg::*;
    #(
    parameter int MAX_BOXES = MAX_BOXES_DEF
    )(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    output logic              full,
    input  logic signed [15:0] i_box_left,
    input  logic signed [15:0] i_box_top,
    input  logic [14:0]       i_box_width,
    input  logic [14:0]       i_box_height,
    input  logic [15:0]       i_score,
    input  logic              i_last_box,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    output logic              empty,
    input  logic              pop,
    output logic [5:0]        o_kept_index,
    output logic              o_last_kept,
    output logic              o_capacity_overflow
);

    localparam int AW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;

    t_box         in_box;
    t_box         rd_box;
    logic [$bits(t_box)-1:0] rd_data;
    logic         we;
    logic [AW-1:0] waddr, raddr;
    t_job         job;
    t_back_status status;
    t_result      result;

    assign in_box.left   = i_box_left;
    assign in_box.top    = i_box_top;
    assign in_box.width  = i_box_width;
    assign in_box.height = i_box_height;
    assign in_box.score  = i_score;
    assign rd_box        = t_box'(rd_data);

    iounms_front #(.MAX_BOXES(MAX_BOXES)) u_front (
        .i_clk, .i_rst_n, .push, .full, .i_last_box,
        .o_we(we), .o_waddr(waddr), .o_job(job), .i_status(status)
    );

    iounms_ram #(.WIDTH($bits(t_box)), .DEPTH(MAX_BOXES)) u_ram (
        .i_clk, .i_we(we), .i_waddr(waddr), .i_wdata(in_box),
        .i_raddr(raddr), .o_rdata(rd_data)
    );

    iounms_back #(.MAX_BOXES(MAX_BOXES)) u_back (
        .i_clk, .i_rst_n, .i_job(job), .o_status(status), .o_raddr(raddr),
        .i_rbox(rd_box), .i_cfg_valid, .o_cfg_ready, .i_cfg_data,
        .empty, .pop, .o_result(result)
    );

    assign o_kept_index        = result.index;
    assign o_last_kept         = result.last;
    assign o_capacity_overflow = result.overflow;

endmodule

FILE: sv/iounms_checker.sv
module iounms_checker (
    input logic       i_clk,
    input logic       i_rst_n,
    input logic       push,
    input logic       full,
    input logic       i_last_box,
    input logic       empty,
    input logic       pop,
    input logic [5:0] o_kept_index,
    input logic       o_last_kept
);

    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("result queue not empty after reset");

    a_close_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push && !full && i_last_box |=> full)
        else $error("input still open after the closing item");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_kept_index) && $stable(o_last_kept))
        else $error("waiting result changed");

endmodule

bind iou_non_maximum_suppression_core iounms_checker u_checker (.*);

FILE: sim/nms_checker.sv
module nms_checker
    import iounms_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              push,
    input  logic              full,
    input  logic signed [15:0] i_box_left,
    input  logic signed [15:0] i_box_top,
    input  logic [14:0]       i_box_width,
    input  logic [14:0]       i_box_height,
    input  logic [15:0]       i_score,
    input  logic              i_last_box,
    input  logic              i_cfg_valid,
    input  logic              o_cfg_ready,
    input  logic [15:0]       i_cfg_data,
    input  logic              empty,
    input  logic              pop,
    input  logic [5:0]        o_kept_index,
    input  logic              o_last_kept,
    input  logic              o_capacity_overflow,
    output int                o_fail_count,
    output int                o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    t_box      box_mem [MAX_BOXES_DEF];
    int        rank [MAX_BOXES_DEF];
    bit        gone [MAX_BOXES_DEF];
    int        box_count;
    bit        dropped;
    logic [15:0] threshold;
    t_result   kept_fifo [$];
    int        fail_count = 0;

    function automatic bit too_close(int a, int b, logic [15:0] thr);
        longint x1, y1, x2, y2, iw, ih, inter, uni;
        longint ra, rb, ba, bb;
        x1 = box_mem[a].left > box_mem[b].left ? box_mem[a].left : box_mem[b].left;
        y1 = box_mem[a].top > box_mem[b].top ? box_mem[a].top : box_mem[b].top;
        ra = longint'(box_mem[a].left) + box_mem[a].width;
        rb = longint'(box_mem[b].left) + box_mem[b].width;
        ba = longint'(box_mem[a].top) + box_mem[a].height;
        bb = longint'(box_mem[b].top) + box_mem[b].height;
        x2 = ra < rb ? ra : rb;
        y2 = ba < bb ? ba : bb;
        iw = x2 > x1 ? x2 - x1 : 0;
        ih = y2 > y1 ? y2 - y1 : 0;
        inter = iw * ih;
        uni = longint'(box_mem[a].width) * box_mem[a].height
            + longint'(box_mem[b].width) * box_mem[b].height - inter;
        if (uni == 0) return 0;
        return inter * 65536 > longint'(thr) * uni;
    endfunction

    task automatic suppress_set();
        int i, j, cur, a;
        t_result r;
        int first;
        first = kept_fifo.size();
        for (i = 0; i < box_count; i++) begin
            j = i;
            cur = i;
            while (j > 0 && box_mem[rank[j-1]].score < box_mem[cur].score) begin
                rank[j] = rank[j-1];
                j--;
            end
            rank[j] = cur;
            gone[i] = 0;
        end
        for (i = 0; i < box_count; i++) begin
            a = rank[i];
            if (!gone[a]) begin
                r.index = a[5:0];
                r.last = 0;
                r.overflow = dropped;
                kept_fifo = {kept_fifo, r};
                for (j = i + 1; j < box_count; j++)
                    if (!gone[rank[j]] && too_close(a, rank[j], threshold))
                        gone[rank[j]] = 1;
            end
        end
        if (kept_fifo.size() > first) kept_fifo[$].last = 1;
        box_count = 0;
        dropped = 0;
    endtask

    always @(posedge i_clk) begin
        t_result want;
        if (!i_rst_n) begin
            box_count = 0;
            dropped = 0;
            threshold = THR_RESET;
        end else begin
            if (i_cfg_valid && o_cfg_ready) threshold = i_cfg_data;
            if (push && !full) begin
                if (box_count < MAX_BOXES_DEF) begin
                    box_mem[box_count] = '{i_box_left, i_box_top, i_box_width,
                                           i_box_height, i_score};
                    box_count = box_count + 1;
                end else begin
                    dropped = 1;
                end
                if (i_last_box) suppress_set();
            end
            if (pop && !empty) begin
                if (kept_fifo.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("Unexpected item: index %0d", o_kept_index);
                end else begin
                    want = kept_fifo.pop_front();
                    if (want !== {o_kept_index, o_last_kept, o_capacity_overflow}) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("Mismatch: expected idx %0d last %0b ovf %0b, got %0d %0b %0b",
                                want.index, want.last, want.overflow,
                                o_kept_index, o_last_kept, o_capacity_overflow);
                    end
                end
            end
        end
    end

    assign o_fail_count = fail_count;
    assign o_pending = kept_fifo.size();
endmodule

FILE: sim/testbench.sv
module testbench;
    import iounms_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    logic              i_clk;
    logic              i_rst_n;
    logic              push;
    logic              full;
    logic signed [15:0] i_box_left;
    logic signed [15:0] i_box_top;
    logic [14:0]       i_box_width;
    logic [14:0]       i_box_height;
    logic [15:0]       i_score;
    logic              i_last_box;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [15:0]       i_cfg_data;
    logic              empty;
    logic              pop;
    logic [5:0]        o_kept_index;
    logic              o_last_kept;
    logic              o_capacity_overflow;
    int                fail_count;
    int                pending;
    int                send_idle_pct;
    int                pop_stall_pct;
    bit                hold_pop;

    iou_non_maximum_suppression_core u_top (.*);

    nms_checker u_check (.*, .o_fail_count(fail_count), .o_pending(pending));

    initial begin
        i_clk = 0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #20ms;
        $display("Regression FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || hold_pop) pop <= 0;
        else pop <= ($urandom_range(99) >= pop_stall_pct);
    end

    task automatic offer_box(int l, int t, int w, int h, int s, bit last);
        while ($urandom_range(99) < send_idle_pct) begin
            push <= 0;
            @(posedge i_clk);
        end
        push <= 1;
        i_box_left <= 16'(l);
        i_box_top <= 16'(t);
        i_box_width <= 15'(w);
        i_box_height <= 15'(h);
        i_score <= 16'(s);
        i_last_box <= last;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
    endtask

    task automatic random_set(int n, int style);
        int k;
        int bx, by;
        bx = int'($urandom_range(200)) - 100;
        by = int'($urandom_range(200)) - 100;
        for (k = 0; k < n; k++) begin
            if (style == 0)
                offer_box(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                          int'($urandom), k == n - 1);
            else
                offer_box(bx + int'($urandom_range(30)), by + int'($urandom_range(30)),
                          int'($urandom_range(60)), int'($urandom_range(60)),
                          (style == 2) ? int'($urandom_range(3)) : int'($urandom),
                          k == n - 1);
        end
    endtask

    task automatic drain();
        push <= 0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (3000) @(posedge i_clk);
    endtask

    task automatic write_threshold(int v);
        i_cfg_valid <= 1;
        i_cfg_data <= 16'(v);
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        i_cfg_valid <= 0;
    endtask

    initial begin
        int phase, k;
        i_rst_n = 0;
        push = 0;
        i_box_left = 0;
        i_box_top = 0;
        i_box_width = 0;
        i_box_height = 0;
        i_score = 0;
        i_last_box = 0;
        i_cfg_valid = 0;
        i_cfg_data = 0;
        hold_pop = 0;
        send_idle_pct = 0;
        pop_stall_pct = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        offer_box(16'sh8000, 16'sh8000, 15'h7fff, 15'h7fff, 16'hffff, 0);
        offer_box(16'sh7fff, 16'sh7fff, 15'h7fff, 15'h7fff, 16'h0000, 0);
        offer_box(10, 10, 0, 0, 16'h8000, 0);
        offer_box(10, 10, 0, 5, 16'h8000, 0);
        offer_box(0, 0, 100, 100, 16'h1234, 0);
        offer_box(5, 5, 100, 100, 16'h1234, 0);
        offer_box(-50, -50, 10, 10, 16'h1234, 1);
        offer_box(0, 0, 0, 0, 0, 1);
        drain();
        write_threshold(16'h0000);
        offer_box(0, 0, 10, 10, 5, 0);
        offer_box(9, 9, 10, 10, 6, 0);
        offer_box(20, 0, 10, 10, 6, 1);
        drain();
        write_threshold(16'hffff);
        offer_box(0, 0, 10, 10, 5, 0);
        offer_box(0, 0, 10, 10, 5, 1);
        drain();

        write_threshold(16'h8000);
        hold_pop = 1;
        fork
            begin
                random_set(70, 1);
                random_set(5, 1);
            end
            begin
                repeat (400) @(posedge i_clk);
                hold_pop = 0;
            end
        join
        drain();

        for (phase = 0; phase < 4; phase++) begin
            send_idle_pct = (phase == 1 || phase == 3) ? (phase == 1 ? 71 : 30) : 0;
            pop_stall_pct = (phase == 2 || phase == 3) ? (phase == 2 ? 71 : 30) : 0;
            write_threshold(int'($urandom));
            for (k = 0; k < 4; k++) random_set(int'($urandom_range(1, 9)), k % 3);
            drain();
        end
        write_threshold(int'(THR_RESET));
        random_set(5, 1);
        drain();

        if (fail_count == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end
endmodule
